// File: src/sfrsc_pkg.sv
// sfrsc_pkg: shared types and constants of the sync frame receiver
// header bytes, register map, event codes and the structs passed between modules
// no dependencies
package sfrsc_pkg;

   // header bytes that open every frame
   localparam logic [7:0] HDR_FIRST  = 8'hA5;
   localparam logic [7:0] HDR_SECOND = 8'h5A;

   // position of the length byte, first body position
   localparam logic [7:0] POS_LENGTH = 8'd2;
   localparam logic [7:0] POS_BODY   = 8'd3;

   // register reset values
   localparam logic [7:0] FRAME_LENGTH_RESET  = 8'd108;
   localparam logic [7:0] TIMEOUT_TICKS_RESET = 8'd10;

   // register map, index taken from paddr bit 2
   localparam int         PADDR_WIDTH = 3;
   localparam logic       REG_FRAME_LENGTH  = 1'b0;
   localparam logic       REG_TIMEOUT_TICKS = 1'b1;

   // input command codes
   localparam logic       CMD_BYTE = 1'b0;
   localparam logic       CMD_TICK = 1'b1;

   // result event codes
   typedef enum logic [2:0] {
      EV_NONE     = 3'd0,
      EV_ACCEPT   = 3'd1,
      EV_REJECT   = 3'd2,
      EV_GOOD     = 3'd3,
      EV_BAD_SUM  = 3'd4,
      EV_TIMEOUT  = 3'd5
   } event_type;

   // configuration handed to the parser
   typedef struct packed {
      logic [7:0] frame_length;
      logic [7:0] timeout_ticks;
   } cfg_type;

   // one result beat
   typedef struct packed {
      event_type  event_res;
      logic [7:0] byte_index;
      logic [7:0] byte_value;
   } result_type;

endpackage

// File: src/sfrsc_chan_if.sv
// sfrsc_chan_if: valid/ready channels of the sync frame receiver
// request channel carries bytes and ticks, response channel carries events
// depends on sfrsc_pkg
interface sfrsc_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] rx_byte;

   modport source (output valid, output command, output rx_byte, input ready);
   modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

interface sfrsc_rsp_if;
   logic                  valid;
   logic                  ready;
   sfrsc_pkg::event_type  event_res;
   logic [7:0]            byte_index;
   logic [7:0]            byte_value;

   modport source (output valid, output event_res, output byte_index, output byte_value,
                   input ready);
   modport sink   (input valid, input event_res, input byte_index, input byte_value,
                   output ready);
endinterface

// File: src/sfrsc_csr.sv
// sfrsc_csr: APB register file holding frame_length and timeout_ticks
// depends on sfrsc_pkg
module sfrsc_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [sfrsc_pkg::PADDR_WIDTH-1:0]  paddr,
   input  logic [31:0]                        pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready,
   output sfrsc_pkg::cfg_type                 cfg
);
   import sfrsc_pkg::*;

   logic [7:0] frame_length_ff, frame_length_in;
   logic [7:0] timeout_ticks_ff, timeout_ticks_in;
   logic       wr_en;
   logic       reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite & pready;
   assign reg_sel = paddr[2];

   // write decode
   always_comb begin
      frame_length_in  = frame_length_ff;
      timeout_ticks_in = timeout_ticks_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_FRAME_LENGTH:  frame_length_in  = pwdata[7:0];
            REG_TIMEOUT_TICKS: timeout_ticks_in = pwdata[7:0];
            default:           frame_length_in  = frame_length_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_length_ff  <= FRAME_LENGTH_RESET;
         timeout_ticks_ff <= TIMEOUT_TICKS_RESET;
      end else begin
         frame_length_ff  <= frame_length_in;
         timeout_ticks_ff <= timeout_ticks_in;
      end
   end

   // read mux
   always_comb begin
      unique case (reg_sel)
         REG_FRAME_LENGTH:  prdata = {24'd0, frame_length_ff};
         REG_TIMEOUT_TICKS: prdata = {24'd0, timeout_ticks_ff};
         default:           prdata = 32'd0;
      endcase
   end

   assign cfg.frame_length  = frame_length_ff;
   assign cfg.timeout_ticks = timeout_ticks_ff;

endmodule

// File: src/sfrsc_parser.sv
// sfrsc_parser: frame position, running sum and timeout counter
// works out the event for one byte or tick and updates state on step
// depends on sfrsc_pkg
module sfrsc_parser (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic                    command,
   input  logic [7:0]              rx_byte,
   input  sfrsc_pkg::cfg_type      cfg,
   output sfrsc_pkg::result_type   result
);
   import sfrsc_pkg::*;

   logic [7:0] pos_ff, pos_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] tmo_ff, tmo_in;
   logic [8:0] pos_next;
   logic       hdr_ok;

   assign pos_next = {1'b0, pos_ff} + 9'd1;

   // header byte check for the first three positions
   always_comb begin
      unique case (pos_ff)
         8'd0:       hdr_ok = (rx_byte == HDR_FIRST);
         8'd1:       hdr_ok = (rx_byte == HDR_SECOND);
         POS_LENGTH: hdr_ok = (rx_byte == cfg.frame_length);
         default:    hdr_ok = 1'b0;
      endcase
   end

   // next state and result
   always_comb begin
      pos_in            = pos_ff;
      sum_in            = sum_ff;
      tmo_in            = tmo_ff;
      result.event_res  = EV_NONE;
      result.byte_index = pos_ff;
      result.byte_value = 8'd0;
      if (command == CMD_BYTE) begin
         result.byte_value = rx_byte;
         tmo_in            = cfg.timeout_ticks;
         if (pos_ff < POS_BODY) begin
            if (hdr_ok) begin
               sum_in           = sum_ff + rx_byte;
               pos_in           = pos_next[7:0];
               result.event_res = EV_ACCEPT;
            end else begin
               sum_in           = 8'd0;
               pos_in           = 8'd0;
               result.event_res = EV_REJECT;
            end
         end else if (pos_next >= {1'b0, cfg.frame_length}) begin
            // last byte carries the sum
            result.event_res = (rx_byte == sum_ff) ? EV_GOOD : EV_BAD_SUM;
            sum_in           = 8'd0;
            pos_in           = 8'd0;
         end else begin
            sum_in           = sum_ff + rx_byte;
            pos_in           = pos_next[7:0];
            result.event_res = EV_ACCEPT;
         end
      end else if (tmo_ff != 8'd0) begin
         // tick counts the timeout down
         tmo_in = tmo_ff - 8'd1;
         if (tmo_ff == 8'd1) begin
            result.event_res = EV_TIMEOUT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 8'd0;
         sum_ff <= 8'd0;
         tmo_ff <= 8'd0;
      end else if (step) begin
         pos_ff <= pos_in;
         sum_ff <= sum_in;
         tmo_ff <= tmo_in;
      end
   end

endmodule

// File: src/sync_frame_receiver_with_sum_check_top.sv
// sync_frame_receiver_with_sum_check_top: frame receiver with header sync and sum check
// input register, parser, result register; APB register file
// depends on sfrsc_pkg, sfrsc_chan_if, sfrsc_csr, sfrsc_parser
//
// Usage
//   req_bus: one beat per received byte (command 0) or millisecond tick (command 1).
//   rsp_bus: exactly one beat per request beat, in order: event code, the frame
//            position handled and the byte value (zero for ticks).
//   APB port: frame_length at address 0, timeout_ticks at address 4; write only
//            while no request is in flight.
// Path: a request beat is held in the input register, then its response beat in the
//   result register, from which rsp_bus takes it.
// Throughput: one beat per cycle while rsp ready is high; the input register hands on
//   an item whenever the result register is empty or its beat is being taken.
// Reset: synchronous, clears the frame position, sum and timeout counter, empties
//   both registers and loads frame_length 108 and timeout_ticks 10.
// Stall: while rsp ready is low the result register holds its beat and the input
//   register still takes one further beat; req ready then drops until the
//   result beat is taken.
module sync_frame_receiver_with_sum_check_top (
   input  logic                               clock,
   input  logic                               reset,
   sfrsc_req_if.sink                          req_bus,
   sfrsc_rsp_if.source                        rsp_bus,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [sfrsc_pkg::PADDR_WIDTH-1:0]  paddr,
   input  logic [31:0]                        pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready
);
   import sfrsc_pkg::*;

   cfg_type    cfg;
   result_type result;

   logic       in_valid_ff, in_valid_in;
   logic       in_command_ff;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;
   logic       step;
   logic       req_take;

   // register file
   sfrsc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // handshake control
   assign step          = in_valid_ff & (~out_valid_ff | rsp_bus.ready);
   assign req_bus.ready = ~in_valid_ff | step;
   assign req_take      = req_bus.valid & req_bus.ready;

   always_comb begin
      in_valid_in  = req_take | (in_valid_ff & ~step);
      out_valid_in = step | (out_valid_ff & ~rsp_bus.ready);
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_command_ff <= req_bus.command;
         in_byte_ff    <= req_bus.rx_byte;
      end
   end

   // parser state and event logic
   sfrsc_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .command (in_command_ff),
      .rx_byte (in_byte_ff),
      .cfg     (cfg),
      .result  (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_ff <= result;
      end
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.event_res  = out_ff.event_res;
   assign rsp_bus.byte_index = out_ff.byte_index;
   assign rsp_bus.byte_value = out_ff.byte_value;

endmodule
